// ----- rtl/lpl_pkg.sv -----
// ----------------------------------------------------------------------------
// lpl_pkg
// Shared types and constants of the look-ahead peak limiter.
// ----------------------------------------------------------------------------
package lpl_pkg;

    localparam int SAMPLE_W = 24;
    localparam int GAIN_W   = 16;
    localparam int PROD_W   = 43;

    localparam logic [GAIN_W-1:0] UNITY_GAIN   = 16'd32768;
    localparam logic [GAIN_W-1:0] CEIL_RESET   = 16'd32768;
    localparam logic [10:0]       LOOK_RESET   = 11'd240;
    localparam logic [GAIN_W-1:0] COEFF_RESET  = 16'd65508;

    typedef enum logic [1:0] {
        CFG_CEILING   = 2'd0,
        CFG_LOOKAHEAD = 2'd1,
        CFG_RELEASE   = 2'd2
    } cfg_index_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV,
        S_FRONT_RD,
        S_FRONT_CHK,
        S_BACK_RD,
        S_BACK_CHK,
        S_PUSH,
        S_HEAD_RD,
        S_WIN,
        S_REL,
        S_MUL_L,
        S_MUL_R,
        S_DONE
    } state_t;

    // Round half up, then clip at the positive full scale.
    function automatic logic signed [SAMPLE_W-1:0] apply_round(
        input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] r;
        begin
            r = (p + PROD_W'(16384)) >>> 15;
            if (r > PROD_W'(8388607))
            begin
                r = PROD_W'(8388607);
            end
            apply_round = r[SAMPLE_W-1:0];
        end
    endfunction

endpackage

// ----- rtl/lookahead_peak_limiter_core.sv -----
// ----------------------------------------------------------------------------
// lookahead_peak_limiter_core
// Look-ahead brickwall limiter with a sliding-window minimum gain.
// ----------------------------------------------------------------------------
// Per frame, a 15-step restoring divider forms the target gain when the peak
// is above the ceiling, the min-gain deque is trimmed one entry at a time
// through its single-port read (a read state, then a check state), and one
// shared multiplier does the release step and both channel gains in turn. The
// block takes no new frame until the current one is finished; its result waits
// in an output register. No clearing pass follows reset.
module lookahead_peak_limiter_core #(
    parameter int MAX_LOOKAHEAD = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic signed [23:0] sample_left,
    input  logic signed [23:0] sample_right,
    input  logic [23:0] true_peak,
    output logic        out_valid,
    input  logic        out_stall,
    output logic signed [23:0] out_left,
    output logic signed [23:0] out_right,
    output logic [15:0] gain_applied,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import lpl_pkg::*;

    localparam int ADDR_W = $clog2(MAX_LOOKAHEAD);
    localparam int PTR_W  = ADDR_W + 1;
    localparam int DQ_W   = PTR_W + GAIN_W;

    function automatic logic [ADDR_W-1:0] wrap(input logic [PTR_W:0] v);
        begin
            if (v >= (PTR_W+1)'(MAX_LOOKAHEAD))
            begin
                wrap = ADDR_W'(v - (PTR_W+1)'(MAX_LOOKAHEAD));
            end
            else
            begin
                wrap = ADDR_W'(v);
            end
        end
    endfunction

    state_t state_reg, state_next;
    logic [15:0] ceil_reg, coeff_reg;
    logic [10:0] look_reg;
    logic [23:0] peak_reg, peak_next, rem_reg, rem_next;
    logic [14:0] quot_reg, quot_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic [15:0] target_reg, target_next, win_reg, win_next, gain_reg, gain_next;
    logic [ADDR_W-1:0] head_reg, head_next, wslot_reg, wslot_next;
    logic [PTR_W-1:0]  count_reg, count_next, fpos_reg, fpos_next, fc_reg, fc_next;
    logic signed [PROD_W-1:0] mul_reg;
    logic signed [23:0] left_res_reg, left_res_next;
    logic        out_valid_reg, out_valid_next;
    logic signed [23:0] out_left_reg, out_left_next, out_right_reg, out_right_next;
    logic [15:0] out_gain_reg, out_gain_next;

    logic        mul_en;
    logic signed [24:0] mul_a;
    logic signed [17:0] mul_b;

    logic              dq_we, dq_re, au_re;
    logic [ADDR_W-1:0] dq_waddr, dq_raddr, au_raddr;
    logic [DQ_W-1:0]   dq_rdata;
    logic [47:0]       au_rdata;

    logic [PTR_W-1:0]  eff_l, age;
    logic [PTR_W-1:0]  dq_idx;
    logic [15:0]       dq_gain;
    logic [24:0]       div_t;
    logic              filled;
    logic [15:0]       win;

    assign cfg_ready    = 1'b1;
    assign in_stall     = (state_reg != S_IDLE);
    assign out_valid    = out_valid_reg;
    assign out_left     = out_left_reg;
    assign out_right    = out_right_reg;
    assign gain_applied = out_gain_reg;

    assign dq_idx  = dq_rdata[DQ_W-1:GAIN_W];
    assign dq_gain = dq_rdata[GAIN_W-1:0];
    assign age     = fpos_reg - dq_idx;
    assign div_t   = {rem_reg, 1'b0};
    assign filled  = ((PTR_W+1)'(fc_reg) + (PTR_W+1)'(1)) >= (PTR_W+1)'(eff_l);
    assign win     = filled ? dq_gain : UNITY_GAIN;

    always_comb
    begin
        if (look_reg == 11'd0)
        begin
            eff_l = PTR_W'(1);
        end
        else if (32'(look_reg) > 32'(MAX_LOOKAHEAD))
        begin
            eff_l = PTR_W'(MAX_LOOKAHEAD);
        end
        else
        begin
            eff_l = PTR_W'(look_reg);
        end
    end

    lpl_ram #(.WIDTH(DQ_W), .DEPTH(MAX_LOOKAHEAD)) u_deque_ram (
        .clk   (clk),
        .we    (dq_we),
        .waddr (dq_waddr),
        .wdata ({fpos_reg, target_reg}),
        .re    (dq_re),
        .raddr (dq_raddr),
        .rdata (dq_rdata)
    );

    lpl_ram #(.WIDTH(48), .DEPTH(MAX_LOOKAHEAD)) u_delay_ram (
        .clk   (clk),
        .we    (in_valid && !in_stall),
        .waddr (wslot_reg),
        .wdata ({sample_left, sample_right}),
        .re    (au_re),
        .raddr (au_raddr),
        .rdata (au_rdata)
    );

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ceil_reg  <= CEIL_RESET;
            look_reg  <= LOOK_RESET;
            coeff_reg <= COEFF_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_CEILING:   ceil_reg  <= (cfg_data > UNITY_GAIN) ? UNITY_GAIN : cfg_data;
                CFG_LOOKAHEAD: look_reg  <= cfg_data[10:0];
                CFG_RELEASE:   coeff_reg <= cfg_data;
                default:       ;
            endcase
        end
    end

    // Shared multiplier
    always_ff @(posedge clk)
    begin
        if (mul_en)
        begin
            mul_reg <= PROD_W'(mul_a * mul_b);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            fpos_reg      <= '0;
            fc_reg        <= '0;
            wslot_reg     <= '0;
            gain_reg      <= UNITY_GAIN;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            fpos_reg      <= fpos_next;
            fc_reg        <= fc_next;
            wslot_reg     <= wslot_next;
            gain_reg      <= gain_next;
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        peak_reg      <= peak_next;
        rem_reg       <= rem_next;
        quot_reg      <= quot_next;
        target_reg    <= target_next;
        win_reg       <= win_next;
        left_res_reg  <= left_res_next;
        out_left_reg  <= out_left_next;
        out_right_reg <= out_right_next;
        out_gain_reg  <= out_gain_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        peak_next      = peak_reg;
        rem_next       = rem_reg;
        quot_next      = quot_reg;
        cnt_next       = cnt_reg;
        target_next    = target_reg;
        win_next       = win_reg;
        gain_next      = gain_reg;
        head_next      = head_reg;
        count_next     = count_reg;
        fpos_next      = fpos_reg;
        fc_next        = fc_reg;
        wslot_next     = wslot_reg;
        left_res_next  = left_res_reg;
        out_valid_next = out_valid_reg;
        out_left_next  = out_left_reg;
        out_right_next = out_right_reg;
        out_gain_next  = out_gain_reg;
        mul_en   = 1'b0;
        mul_a    = '0;
        mul_b    = '0;
        dq_we    = 1'b0;
        dq_re    = 1'b0;
        au_re    = 1'b0;
        dq_waddr = wrap((PTR_W+1)'(head_reg) + (PTR_W+1)'(count_reg));
        dq_raddr = head_reg;
        au_raddr = wrap((PTR_W+1)'(wslot_reg) + (PTR_W+1)'(MAX_LOOKAHEAD)
                        - (PTR_W+1)'(eff_l) + (PTR_W+1)'(1));

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    peak_next = true_peak;
                    rem_next  = {ceil_reg, 8'h00};
                    quot_next = '0;
                    cnt_next  = '0;
                    if (true_peak == 24'd0 || {ceil_reg, 8'h00} >= true_peak)
                    begin
                        target_next = UNITY_GAIN;
                        state_next  = S_FRONT_RD;
                    end
                    else
                    begin
                        state_next = S_DIV;
                    end
                end
            end
            S_DIV:
            begin
                if (div_t >= {1'b0, peak_reg})
                begin
                    rem_next  = 24'(div_t - {1'b0, peak_reg});
                    quot_next = {quot_reg[13:0], 1'b1};
                end
                else
                begin
                    rem_next  = div_t[23:0];
                    quot_next = {quot_reg[13:0], 1'b0};
                end
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == 4'd14)
                begin
                    target_next = {1'b0, quot_next};
                    state_next  = S_FRONT_RD;
                end
            end
            S_FRONT_RD:
            begin
                dq_raddr = head_reg;
                if (count_reg == '0)
                begin
                    state_next = S_PUSH;
                end
                else
                begin
                    dq_re      = 1'b1;
                    state_next = S_FRONT_CHK;
                end
            end
            S_FRONT_CHK:
            begin
                if (age >= eff_l)
                begin
                    head_next  = wrap((PTR_W+1)'(head_reg) + (PTR_W+1)'(1));
                    count_next = count_reg - PTR_W'(1);
                    state_next = S_FRONT_RD;
                end
                else
                begin
                    state_next = S_BACK_RD;
                end
            end
            S_BACK_RD:
            begin
                dq_raddr = wrap((PTR_W+1)'(head_reg) + (PTR_W+1)'(count_reg)
                                - (PTR_W+1)'(1));
                if (count_reg == '0)
                begin
                    state_next = S_PUSH;
                end
                else
                begin
                    dq_re      = 1'b1;
                    state_next = S_BACK_CHK;
                end
            end
            S_BACK_CHK:
            begin
                if (dq_gain >= target_reg)
                begin
                    count_next = count_reg - PTR_W'(1);
                    state_next = S_BACK_RD;
                end
                else
                begin
                    state_next = S_PUSH;
                end
            end
            S_PUSH:
            begin
                if (count_reg < PTR_W'(MAX_LOOKAHEAD))
                begin
                    dq_we      = 1'b1;
                    count_next = count_reg + PTR_W'(1);
                end
                state_next = S_HEAD_RD;
            end
            S_HEAD_RD:
            begin
                dq_raddr   = head_reg;
                dq_re      = 1'b1;
                au_re      = 1'b1;
                state_next = S_WIN;
            end
            S_WIN:
            begin
                win_next = win;
                if (win < gain_reg)
                begin
                    gain_next  = win;
                    state_next = S_MUL_L;
                end
                else
                begin
                    mul_en     = 1'b1;
                    mul_a      = 25'(win - gain_reg);
                    mul_b      = signed'({2'b00, coeff_reg});
                    state_next = S_REL;
                end
            end
            S_REL:
            begin
                gain_next  = win_reg - 16'(mul_reg >>> 16);
                state_next = S_MUL_L;
            end
            S_MUL_L:
            begin
                mul_en     = 1'b1;
                mul_a      = 25'(signed'(au_rdata[47:24]));
                mul_b      = signed'({2'b00, gain_reg});
                state_next = S_MUL_R;
            end
            S_MUL_R:
            begin
                left_res_next = apply_round(mul_reg);
                mul_en        = 1'b1;
                mul_a         = 25'(signed'(au_rdata[23:0]));
                mul_b         = signed'({2'b00, gain_reg});
                state_next    = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_left_next  = filled ? left_res_reg : '0;
                    out_right_next = filled ? apply_round(mul_reg) : '0;
                    out_gain_next  = gain_reg;
                    wslot_next     = wrap((PTR_W+1)'(wslot_reg) + (PTR_W+1)'(1));
                    fpos_next      = fpos_reg + PTR_W'(1);
                    if (fc_reg < PTR_W'(MAX_LOOKAHEAD))
                    begin
                        fc_next = fc_reg + PTR_W'(1);
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= PTR_W'(MAX_LOOKAHEAD))
        else $error("deque count exceeds depth");

    a_gain_bound: assert property (@(posedge clk) disable iff (!rst_n)
        gain_reg <= UNITY_GAIN)
        else $error("smoothed gain above unity");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg != S_IDLE))
        else $error("item accepted but sequencer idle");

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PUSH && count_reg < PTR_W'(MAX_LOOKAHEAD))
        |=> (count_reg == $past(count_reg) + PTR_W'(1)))
        else $error("deque push lost");
`endif

endmodule

// ----- rtl/lpl_ram.sv -----
// ----------------------------------------------------------------------------
// lpl_ram
// Simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module lpl_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
